// ===== rtl/core/segmented_range_buffer_macros.svh =====
// Assertion macros for the segmented range buffer.
// Used by files that assert; expects clk and rst_n in scope.
`ifndef SEGMENTED_RANGE_BUFFER_MACROS_SVH
`define SEGMENTED_RANGE_BUFFER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SRB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/srb_pkg.sv =====
// Package for the segmented range buffer: field widths, default depths,
// operation and error codes, sequencer states. No dependencies.
`default_nettype none

package srb_pkg;

    // Fixed field widths of the ports
    localparam int VALUE_W  = 64;
    localparam int INDEX_W  = 11;
    localparam int START_W  = 13;
    localparam int COUNT_W  = 13;
    localparam int COMMIT_W = 11;
    localparam int KIND_W   = 3;
    localparam int ERR_W    = 2;

    // Default configuration
    localparam int DEF_ELEMENT_DEPTH = 4096;
    localparam int DEF_RANGE_DEPTH   = 1024;
    localparam int DEF_ELEMENT_WIDTH = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 3'd0,
        KIND_APPEND = 3'd1,
        KIND_COMMIT = 3'd2,
        KIND_FILL   = 3'd3,
        KIND_QUERY  = 3'd4
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK         = 2'd0,
        ERR_ELEM_FULL  = 2'd1,
        ERR_TABLE_FULL = 2'd2,
        ERR_BEYOND     = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_QUERY,
        ST_FILL
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/srb_start_mem.sv =====
// Start table memory: one write port, two registered read ports.
// Depends on srb_pkg for default sizes.
`default_nettype none

module srb_start_mem #(
    parameter int DEPTH  = srb_pkg::DEF_RANGE_DEPTH + 1,
    parameter int DATA_W = $clog2(srb_pkg::DEF_ELEMENT_DEPTH + 1),
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/srb_elem_mem.sv =====
// Flat element store, filled in append order.
// Depends on srb_pkg for default sizes.
`default_nettype none

module srb_elem_mem #(
    parameter int DEPTH  = srb_pkg::DEF_ELEMENT_DEPTH,
    parameter int DATA_W = srb_pkg::DEF_ELEMENT_WIDTH,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/segmented_range_buffer.sv =====
// Segmented range buffer: compressed-row store built from appends and commits.
// Input channel in_valid/in_ready carries kind, value, range_num; output
// channel out_valid/out_ready carries one result per input transfer.
// Clear, append, commit and unused kinds finish in the transfer cycle; the
// result is registered and shows the next cycle, and such items can follow
// one per cycle while the receiver keeps taking results.
// A query reads the start table (synchronous read, two read ports); ST_QUERY
// loads the result from the read data, and the input is held off meanwhile.
// A fill that advances the committed count writes one start table entry per
// cycle, from the committed count up to range_num, through the single write
// port; the input is held off during the walk.
// Reset (rst_n, async, low) empties both counts and sets start entry zero;
// no clearing pass is run, the block takes items right after reset.
// A stalled receiver holds the result register; in_ready stays low until the
// pending result is taken (a new transfer may land in the same cycle).
// Depends on srb_pkg, srb_start_mem, srb_elem_mem and the macros header.
`default_nettype none

`include "segmented_range_buffer_macros.svh"

module segmented_range_buffer #(
    parameter int ELEMENT_DEPTH = srb_pkg::DEF_ELEMENT_DEPTH,
    parameter int RANGE_DEPTH   = srb_pkg::DEF_RANGE_DEPTH,
    parameter int ELEMENT_WIDTH = srb_pkg::DEF_ELEMENT_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [srb_pkg::KIND_W-1:0]          kind,
    input  logic signed [srb_pkg::VALUE_W-1:0]  value,
    input  logic [srb_pkg::INDEX_W-1:0]         range_num,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [srb_pkg::START_W-1:0]         range_start,
    output logic [srb_pkg::COUNT_W-1:0]         range_size,
    output logic [srb_pkg::COMMIT_W-1:0]        committed_count,
    output logic [srb_pkg::COUNT_W-1:0]         element_count,
    output logic [srb_pkg::ERR_W-1:0]           error
);

    localparam int START_W  = srb_pkg::START_W;
    localparam int COUNT_W  = srb_pkg::COUNT_W;
    localparam int COMMIT_W = srb_pkg::COMMIT_W;
    localparam int INDEX_W  = srb_pkg::INDEX_W;
    // element count / start value width, element address, range count width
    localparam int ECW  = $clog2(ELEMENT_DEPTH + 1);
    localparam int EAW  = $clog2(ELEMENT_DEPTH);
    localparam int RCW  = $clog2(RANGE_DEPTH + 1);
    localparam int IDXW = (RCW > INDEX_W) ? RCW : INDEX_W;

    localparam logic [ECW-1:0]  ELEM_LIMIT  = ECW'(ELEMENT_DEPTH);
    localparam logic [RCW-1:0]  RANGE_LIMIT = RCW'(RANGE_DEPTH);
    localparam logic [IDXW-1:0] IDX_LIMIT   = IDXW'(RANGE_DEPTH);

    // ---------------- control state ----------------
    srb_pkg::state_t state_reg, state_next;
    logic [ECW-1:0]  stored_reg, stored_next;   // elements stored
    logic [RCW-1:0]  closed_reg, closed_next;   // ranges committed
    logic [ECW-1:0]  base_reg, base_next;       // start table entry zero
    logic [RCW-1:0]  ptr_reg, ptr_next;         // fill walk pointer
    logic [RCW-1:0]  end_reg, end_next;         // fill walk last entry
    logic            q_zero_reg, q_zero_next;   // query hits range zero
    logic            q_open_reg, q_open_next;   // query hits the open range
    logic            out_valid_reg, out_valid_next;

    // ---------------- result register (payload) ----------------
    logic [START_W-1:0]  start_out_reg, start_out_next;
    logic [COUNT_W-1:0]  size_out_reg, size_out_next;
    logic [COMMIT_W-1:0] commit_out_reg, commit_out_next;
    logic [COUNT_W-1:0]  elem_out_reg, elem_out_next;
    srb_pkg::err_t       err_out_reg, err_out_next;

    // ---------------- datapath ----------------
    logic            accept;
    logic            load;
    logic [IDXW-1:0] idx_ext;
    logic [IDXW-1:0] closed_ext;
    logic [ECW-1:0]  res_start;
    logic [ECW-1:0]  res_size;
    logic [ECW-1:0]  start_k;
    srb_pkg::err_t   res_err;

    logic            st_we;
    logic [RCW-1:0]  st_waddr;
    logic [ECW-1:0]  st_wdata;
    logic            st_re;
    logic [RCW-1:0]  st_raddr_a;
    logic [RCW-1:0]  st_raddr_b;
    logic [ECW-1:0]  st_rdata_a;
    logic [ECW-1:0]  st_rdata_b;
    logic            el_we;

    assign idx_ext    = IDXW'(range_num);
    assign closed_ext = IDXW'(closed_reg);
    assign in_ready   = (state_reg == srb_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept     = in_valid && in_ready;

    // Query reads entry k on port a and k+1 on port b; data is used the
    // following cycle. Port b is ignored when k is the open range.
    assign st_re      = accept;
    assign st_raddr_a = RCW'(idx_ext);
    assign st_raddr_b = RCW'(idx_ext) + RCW'(1);

    // Entry zero lives in base_reg, so the memory holds entries 1 and up.
    assign start_k = q_zero_reg ? base_reg : st_rdata_a;

    always_comb
    begin
        state_next  = state_reg;
        stored_next = stored_reg;
        closed_next = closed_reg;
        base_next   = base_reg;
        ptr_next    = ptr_reg;
        end_next    = end_reg;
        q_zero_next = q_zero_reg;
        q_open_next = q_open_reg;
        st_we       = 1'b0;
        st_waddr    = ptr_reg;
        st_wdata    = stored_reg;
        el_we       = 1'b0;
        load        = 1'b0;
        res_start   = '0;
        res_size    = '0;
        res_err     = srb_pkg::ERR_OK;

        case (state_reg)
            srb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (srb_pkg::kind_t'(kind))
                        srb_pkg::KIND_CLEAR:
                        begin
                            stored_next = '0;
                            closed_next = '0;
                            base_next   = '0;
                            load        = 1'b1;
                        end
                        srb_pkg::KIND_APPEND:
                        begin
                            if (stored_reg >= ELEM_LIMIT)
                            begin
                                res_err = srb_pkg::ERR_ELEM_FULL;
                            end
                            else
                            begin
                                el_we       = 1'b1;
                                stored_next = stored_reg + ECW'(1);
                            end
                            load = 1'b1;
                        end
                        srb_pkg::KIND_COMMIT:
                        begin
                            if (closed_reg >= RANGE_LIMIT)
                            begin
                                res_err = srb_pkg::ERR_TABLE_FULL;
                            end
                            else
                            begin
                                closed_next = closed_reg + RCW'(1);
                                st_we       = 1'b1;
                                st_waddr    = closed_reg + RCW'(1);
                            end
                            load = 1'b1;
                        end
                        srb_pkg::KIND_FILL:
                        begin
                            if (idx_ext > IDX_LIMIT)
                            begin
                                res_err = srb_pkg::ERR_TABLE_FULL;
                                load    = 1'b1;
                            end
                            else if (idx_ext > closed_ext)
                            begin
                                // walk from the open range up to the target
                                ptr_next   = closed_reg;
                                end_next   = RCW'(idx_ext);
                                state_next = srb_pkg::ST_FILL;
                            end
                            else
                            begin
                                load = 1'b1;
                            end
                        end
                        srb_pkg::KIND_QUERY:
                        begin
                            if (idx_ext > closed_ext)
                            begin
                                res_err = srb_pkg::ERR_BEYOND;
                                load    = 1'b1;
                            end
                            else
                            begin
                                q_zero_next = (idx_ext == '0);
                                q_open_next = (idx_ext == closed_ext);
                                state_next  = srb_pkg::ST_QUERY;
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            srb_pkg::ST_QUERY:
            begin
                res_start  = q_zero_reg ? '0 : st_rdata_a;
                // open range is sized up to the current fill
                res_size   = q_open_reg ? (stored_reg - start_k) : (st_rdata_b - start_k);
                load       = 1'b1;
                state_next = srb_pkg::ST_IDLE;
            end
            srb_pkg::ST_FILL:
            begin
                if (ptr_reg == '0)
                begin
                    base_next = stored_reg;
                end
                else
                begin
                    st_we = 1'b1;
                end
                if (ptr_reg == end_reg)
                begin
                    closed_next = end_reg;
                    load        = 1'b1;
                    state_next  = srb_pkg::ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + RCW'(1);
                end
            end
            default:
            begin
                state_next = srb_pkg::ST_IDLE;
            end
        endcase

        // result register: counts are taken after this item
        start_out_next  = load ? START_W'(res_start) : start_out_reg;
        size_out_next   = load ? COUNT_W'(res_size) : size_out_reg;
        commit_out_next = load ? COMMIT_W'(closed_next) : commit_out_reg;
        elem_out_next   = load ? COUNT_W'(stored_next) : elem_out_reg;
        err_out_next    = load ? res_err : err_out_reg;
        out_valid_next  = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srb_pkg::ST_IDLE;
            stored_reg    <= '0;
            closed_reg    <= '0;
            base_reg      <= '0;
            ptr_reg       <= '0;
            end_reg       <= '0;
            q_zero_reg    <= 1'b0;
            q_open_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stored_reg    <= stored_next;
            closed_reg    <= closed_next;
            base_reg      <= base_next;
            ptr_reg       <= ptr_next;
            end_reg       <= end_next;
            q_zero_reg    <= q_zero_next;
            q_open_reg    <= q_open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_out_reg  <= start_out_next;
        size_out_reg   <= size_out_next;
        commit_out_reg <= commit_out_next;
        elem_out_reg   <= elem_out_next;
        err_out_reg    <= err_out_next;
    end

    assign out_valid       = out_valid_reg;
    assign range_start     = start_out_reg;
    assign range_size      = size_out_reg;
    assign committed_count = commit_out_reg;
    assign element_count   = elem_out_reg;
    assign error           = err_out_reg;

    // ---------------- memories ----------------
    srb_start_mem #(
        .DEPTH  (RANGE_DEPTH + 1),
        .DATA_W (ECW)
    ) u_start_mem (
        .clk     (clk),
        .we      (st_we),
        .waddr   (st_waddr),
        .wdata   (st_wdata),
        .re      (st_re),
        .raddr_a (st_raddr_a),
        .raddr_b (st_raddr_b),
        .rdata_a (st_rdata_a),
        .rdata_b (st_rdata_b)
    );

    srb_elem_mem #(
        .DEPTH  (ELEMENT_DEPTH),
        .DATA_W (ELEMENT_WIDTH)
    ) u_elem_mem (
        .clk   (clk),
        .we    (el_we),
        .waddr (stored_reg[EAW-1:0]),
        .wdata (value[ELEMENT_WIDTH-1:0])
    );

    // ---------------- assertions ----------------
    `SRB_ASSERT_NOW(a_ready_needs_room, in_ready, (!out_valid_reg || out_ready), "transfer taken while result register is blocked")
    `SRB_ASSERT_NXT(a_query_one_read, (state_reg == srb_pkg::ST_QUERY), (out_valid_reg && (state_reg == srb_pkg::ST_IDLE)), "query result not loaded after start table read")
    `SRB_ASSERT_NOW(a_fill_in_bounds, (state_reg == srb_pkg::ST_FILL), ((ptr_reg <= end_reg) && (end_reg <= RANGE_LIMIT) && (ptr_reg >= closed_reg)), "fill walk left its span")
    `SRB_ASSERT_NOW(a_counts_in_range, 1'b1, ((closed_reg <= RANGE_LIMIT) && (stored_reg <= ELEM_LIMIT)), "count beyond store depth")

endmodule

`default_nettype wire
